// File: design/rigid_transform_crop_box_filter_top_macros.svh
// Assertion macros for the rigid-transform crop box filter.
// Used by the top level only; no other dependencies.
`ifndef RIGID_TRANSFORM_CROP_BOX_FILTER_TOP_MACROS_SVH
`define RIGID_TRANSFORM_CROP_BOX_FILTER_TOP_MACROS_SVH

// The condition must never hold outside reset.
`define RTCBF_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed: forbidden condition");

// The consequent must hold in the same cycle as the antecedent.
`define RTCBF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define RTCBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/rtcbf_pkg.sv
// Shared constants, types and helper functions of the crop box filter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package rtcbf_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int QUAT_WIDTH      = 16;
    localparam int COUNT_WIDTH     = 32;
    localparam int OUT_COUNT_WIDTH = 32;

    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam int QFRAC      = QUAT_WIDTH - 1;
    localparam int CFRAC      = 2 * QFRAC;
    localparam int QPROD_WIDTH = 2 * QUAT_WIDTH;
    localparam int COEF_WIDTH = 2 * QUAT_WIDTH + 2;
    localparam int COEF_LO    = (COEF_WIDTH + 1) / 2;
    localparam int COEF_HI    = COEF_WIDTH - COEF_LO;
    localparam int PH_WIDTH   = COEF_HI + COORD_WIDTH;
    localparam int PL_WIDTH   = COEF_LO + 1 + COORD_WIDTH;
    localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int AXIS_WIDTH = SUM_WIDTH - CFRAC;
    localparam int TEST_WIDTH = AXIS_WIDTH + 1;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {{(COEF_WIDTH - CFRAC - 1){1'b0}}, 1'b1, {CFRAC{1'b0}}};

    localparam int S_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int S_TUSER_WIDTH = 1;
    localparam int M_TDATA_WIDTH = ((3 * OUT_COUNT_WIDTH + 7) / 8) * 8;
    localparam int VERDICT_WIDTH = 2;
    localparam int M_TUSER_WIDTH = VERDICT_WIDTH;

    localparam logic [VERDICT_WIDTH-1:0] VERDICT_KEPT      = VERDICT_WIDTH'(0);
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_REMOVED   = VERDICT_WIDTH'(1);
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_NONFINITE = VERDICT_WIDTH'(2);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRANS_X = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRANS_Y = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRANS_Z = CFG_INDEX_WIDTH'(3);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_X   = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_Y   = CFG_INDEX_WIDTH'(5);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_Z   = CFG_INDEX_WIDTH'(6);

    localparam logic [CFG_DATA_WIDTH-1:0] QUAT_RESET = 64'h7FFF_0000_0000_0000;

    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_WIDTH  = $clog2(SETTLE_CYCLES + 1);

    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_WIDTH   = $clog2(FIFO_DEPTH);
    localparam int FIFO_COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          nonfinite;
        logic                          last;
    } point_t;

    typedef struct packed {
        logic [2:0][2:0][COEF_WIDTH-1:0] coef;
        logic [2:0][COORD_WIDTH-1:0]     trans;
        logic [2:0][COORD_WIDTH-1:0]     lim_lo;
        logic [2:0][COORD_WIDTH-1:0]     lim_hi;
        logic                            busy;
    } xform_t;

    function automatic logic signed [QUAT_WIDTH-1:0] quat_field(
        input logic [CFG_DATA_WIDTH-1:0] v,
        input int                        k
    );
        logic [2*CFG_DATA_WIDTH-1:0] ext;
        ext = {{CFG_DATA_WIDTH{1'b0}}, v};
        return ext[k*QUAT_WIDTH +: QUAT_WIDTH];
    endfunction

    function automatic logic [COORD_WIDTH-1:0] limit_field(
        input logic [CFG_DATA_WIDTH-1:0] v,
        input int                        k
    );
        logic [2*CFG_DATA_WIDTH-1:0] ext;
        ext = {{CFG_DATA_WIDTH{1'b0}}, v};
        return ext[k*COORD_WIDTH +: COORD_WIDTH];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

endpackage

// File: design/rtcbf_cfg.sv
// Configuration registers and rotation coefficient precompute.
// Depends on rtcbf_pkg.
`timescale 1ns / 1ps

module rtcbf_cfg (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rtcbf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rtcbf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output rtcbf_pkg::xform_t                     xform
);
    import rtcbf_pkg::*;

    logic [CFG_DATA_WIDTH-1:0]        quat_reg;
    logic [2:0][COORD_WIDTH-1:0]      trans_reg;
    logic [2:0][CFG_DATA_WIDTH-1:0]   lim_reg;
    logic [SETTLE_WIDTH-1:0]          settle_reg;
    logic [SETTLE_WIDTH-1:0]          settle_next;
    logic                             wr;

    logic signed [QUAT_WIDTH-1:0]  qx, qy, qz, qw;
    logic signed [QPROD_WIDTH-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg;
    logic signed [QPROD_WIDTH-1:0] yz_reg, xw_reg, yw_reg, zw_reg;
    logic signed [COEF_WIDTH-1:0]  e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_xw, e_yw, e_zw;
    logic [2:0][2:0][COEF_WIDTH-1:0] coef_reg;
    logic [2:0][2:0][COEF_WIDTH-1:0] coef_next;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb begin
        settle_next = settle_reg;
        if (wr && cfg_index == REG_QUAT) begin
            settle_next = SETTLE_WIDTH'(SETTLE_CYCLES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg   <= QUAT_RESET;
            trans_reg  <= '0;
            lim_reg    <= '0;
            settle_reg <= '0;
        end else begin
            settle_reg <= settle_next;
            if (wr) begin
                case (cfg_index)
                    REG_QUAT:    quat_reg     <= cfg_data;
                    REG_TRANS_X: trans_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                    REG_TRANS_Y: trans_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                    REG_TRANS_Z: trans_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                    REG_BOX_X:   lim_reg[0]   <= cfg_data;
                    REG_BOX_Y:   lim_reg[1]   <= cfg_data;
                    REG_BOX_Z:   lim_reg[2]   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign qx = quat_field(quat_reg, 0);
    assign qy = quat_field(quat_reg, 1);
    assign qz = quat_field(quat_reg, 2);
    assign qw = quat_field(quat_reg, 3);

    always_ff @(posedge aclk) begin
        xx_reg <= QPROD_WIDTH'(qx) * QPROD_WIDTH'(qx);
        yy_reg <= QPROD_WIDTH'(qy) * QPROD_WIDTH'(qy);
        zz_reg <= QPROD_WIDTH'(qz) * QPROD_WIDTH'(qz);
        xy_reg <= QPROD_WIDTH'(qx) * QPROD_WIDTH'(qy);
        xz_reg <= QPROD_WIDTH'(qx) * QPROD_WIDTH'(qz);
        yz_reg <= QPROD_WIDTH'(qy) * QPROD_WIDTH'(qz);
        xw_reg <= QPROD_WIDTH'(qx) * QPROD_WIDTH'(qw);
        yw_reg <= QPROD_WIDTH'(qy) * QPROD_WIDTH'(qw);
        zw_reg <= QPROD_WIDTH'(qz) * QPROD_WIDTH'(qw);
    end

    assign e_xx = COEF_WIDTH'(xx_reg);
    assign e_yy = COEF_WIDTH'(yy_reg);
    assign e_zz = COEF_WIDTH'(zz_reg);
    assign e_xy = COEF_WIDTH'(xy_reg);
    assign e_xz = COEF_WIDTH'(xz_reg);
    assign e_yz = COEF_WIDTH'(yz_reg);
    assign e_xw = COEF_WIDTH'(xw_reg);
    assign e_yw = COEF_WIDTH'(yw_reg);
    assign e_zw = COEF_WIDTH'(zw_reg);

    always_comb begin
        coef_next[0][0] = COEF_ONE - ((e_yy + e_zz) <<< 1);
        coef_next[0][1] = (e_xy - e_zw) <<< 1;
        coef_next[0][2] = (e_xz + e_yw) <<< 1;
        coef_next[1][0] = (e_xy + e_zw) <<< 1;
        coef_next[1][1] = COEF_ONE - ((e_xx + e_zz) <<< 1);
        coef_next[1][2] = (e_yz - e_xw) <<< 1;
        coef_next[2][0] = (e_xz - e_yw) <<< 1;
        coef_next[2][1] = (e_yz + e_xw) <<< 1;
        coef_next[2][2] = COEF_ONE - ((e_xx + e_yy) <<< 1);
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    always_comb begin
        xform.coef  = coef_reg;
        xform.trans = trans_reg;
        for (int a = 0; a < 3; a++) begin
            xform.lim_lo[a] = limit_field(lim_reg[a], 0);
            xform.lim_hi[a] = limit_field(lim_reg[a], 1);
        end
        xform.busy = (settle_reg != '0);
    end

endmodule

// File: design/rtcbf_front.sv
// Input stage: accepts points, marks non-finite ones and feeds the queue.
// Depends on rtcbf_pkg.
`timescale 1ns / 1ps

module rtcbf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rtcbf_pkg::S_TDATA_WIDTH-1:0] s_tdata,  // coord_x, coord_y, coord_z
    input  logic [rtcbf_pkg::S_TUSER_WIDTH-1:0] s_tuser,  // not_finite
    input  logic                                s_tlast,
    input  logic                                busy,
    input  logic                                full,
    output logic                                push,
    output rtcbf_pkg::point_t                   push_item
);
    import rtcbf_pkg::*;

    logic   front_valid_reg;
    point_t item_reg;
    point_t item_next;
    logic   accept;

    assign s_tready = !busy && (!front_valid_reg || !full);
    assign accept   = s_tvalid && s_tready;
    assign push     = front_valid_reg && !full;

    // Non-finite points get their verdict without the box test, so their coordinates are zeroed.
    always_comb begin
        item_next.nonfinite = s_tuser[0];
        item_next.last      = s_tlast;
        if (s_tuser[0]) begin
            item_next.x = '0;
            item_next.y = '0;
            item_next.z = '0;
        end else begin
            item_next.x = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
            item_next.y = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
            item_next.z = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (accept) begin
            front_valid_reg <= 1'b1;
        end else if (push) begin
            front_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign push_item = item_reg;

endmodule

// File: design/rtcbf_queue.sv
// Short point queue between the input stage and the transform pipeline.
// Depends on rtcbf_pkg.
`timescale 1ns / 1ps

module rtcbf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rtcbf_pkg::point_t push_item,
    input  logic              pop,
    output rtcbf_pkg::point_t head,
    output logic              full,
    output logic              empty
);
    import rtcbf_pkg::*;

    point_t                      mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0]   wptr_reg;
    logic [FIFO_PTR_WIDTH-1:0]   rptr_reg;
    logic [FIFO_COUNT_WIDTH-1:0] count_reg;
    logic [FIFO_COUNT_WIDTH-1:0] count_next;

    function automatic logic [FIFO_PTR_WIDTH-1:0] wrap_inc(input logic [FIFO_PTR_WIDTH-1:0] p);
        return (p == FIFO_PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_WIDTH'(1);
    endfunction

    assign full  = (count_reg == FIFO_COUNT_WIDTH'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_COUNT_WIDTH'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= wrap_inc(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= wrap_inc(rptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// File: design/rtcbf_back.sv
// Transform pipeline: rotation, translation, box test, counters, output register.
// Depends on rtcbf_pkg.
`timescale 1ns / 1ps

module rtcbf_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rtcbf_pkg::xform_t                   xform,
    input  rtcbf_pkg::point_t                   head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rtcbf_pkg::M_TDATA_WIDTH-1:0] m_tdata,  // kept_total, removed_total,
                                                          // nonfinite_total
    output logic [rtcbf_pkg::M_TUSER_WIDTH-1:0] m_tuser,  // verdict
    output logic                                m_tlast
);
    import rtcbf_pkg::*;

    logic en;

    logic v1_reg, v2_reg, v3_reg;
    logic nf1_reg, nf2_reg, nf3_reg;
    logic last1_reg, last2_reg, last3_reg;

    logic [2:0][COORD_WIDTH-1:0]        crd;
    logic [2:0][2:0][PH_WIDTH-1:0]      ph_next;
    logic [2:0][2:0][PL_WIDTH-1:0]      pl_next;
    logic [2:0][2:0][PH_WIDTH-1:0]      ph1_reg;
    logic [2:0][2:0][PL_WIDTH-1:0]      pl1_reg;
    logic [2:0][2:0][PROD_WIDTH-1:0]    prod_next;
    logic [2:0][2:0][PROD_WIDTH-1:0]    prod2_reg;
    logic [2:0][AXIS_WIDTH-1:0]         axis_next;
    logic [2:0][AXIS_WIDTH-1:0]         axis3_reg;
    logic [2:0]                         in_axis;

    logic                     in_box;
    logic [VERDICT_WIDTH-1:0] verdict;
    logic [COUNT_WIDTH-1:0]   kept_reg, removed_reg, nonfinite_reg;
    logic [COUNT_WIDTH-1:0]   kept_bump, removed_bump, nonfinite_bump;

    logic                     m_valid_reg;
    logic [M_TDATA_WIDTH-1:0] m_data_reg;
    logic [M_TUSER_WIDTH-1:0] m_user_reg;
    logic                     m_last_reg;

    assign en  = !m_valid_reg || m_tready;
    assign pop = en && !empty;

    assign crd[0] = head.x;
    assign crd[1] = head.y;
    assign crd[2] = head.z;

    // Each coefficient is split in a signed high half and an unsigned low half.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar k = 0; k < 3; k++) begin : g_term
            logic signed [COEF_HI-1:0]     chi;
            logic signed [COEF_LO:0]       clo;
            logic signed [COORD_WIDTH-1:0] cv;
            logic signed [PH_WIDTH-1:0]    ph_s;
            logic signed [PL_WIDTH-1:0]    pl_s;
            logic signed [PROD_WIDTH-1:0]  ph_e;
            logic signed [PROD_WIDTH-1:0]  pl_e;

            assign chi  = xform.coef[a][k][COEF_WIDTH-1:COEF_LO];
            assign clo  = {1'b0, xform.coef[a][k][COEF_LO-1:0]};
            assign cv   = crd[k];
            assign ph_s = PH_WIDTH'(chi) * PH_WIDTH'(cv);
            assign pl_s = PL_WIDTH'(clo) * PL_WIDTH'(cv);
            assign ph_next[a][k] = ph_s;
            assign pl_next[a][k] = pl_s;

            assign ph_e = PROD_WIDTH'(signed'(ph1_reg[a][k]));
            assign pl_e = PROD_WIDTH'(signed'(pl1_reg[a][k]));
            assign prod_next[a][k] = (ph_e <<< COEF_LO) + pl_e;
        end

        logic signed [SUM_WIDTH-1:0]  sum_s;
        logic signed [TEST_WIDTH-1:0] t_s;
        logic signed [TEST_WIDTH-1:0] lo_s;
        logic signed [TEST_WIDTH-1:0] hi_s;

        assign sum_s = SUM_WIDTH'(signed'(prod2_reg[a][0]))
                     + SUM_WIDTH'(signed'(prod2_reg[a][1]))
                     + SUM_WIDTH'(signed'(prod2_reg[a][2]));
        assign axis_next[a] = AXIS_WIDTH'(sum_s >>> CFRAC);

        assign t_s  = TEST_WIDTH'(signed'(axis3_reg[a]))
                    + TEST_WIDTH'(signed'(xform.trans[a]));
        assign lo_s = TEST_WIDTH'(signed'(xform.lim_lo[a]));
        assign hi_s = TEST_WIDTH'(signed'(xform.lim_hi[a]));
        assign in_axis[a] = (t_s >= lo_s) && (t_s <= hi_s);
    end

    assign in_box = &in_axis;

    always_comb begin
        if (nf3_reg) begin
            verdict = VERDICT_NONFINITE;
        end else if (in_box) begin
            verdict = VERDICT_REMOVED;
        end else begin
            verdict = VERDICT_KEPT;
        end
        kept_bump      = (verdict == VERDICT_KEPT)      ? bump(kept_reg)      : kept_reg;
        removed_bump   = (verdict == VERDICT_REMOVED)   ? bump(removed_reg)   : removed_reg;
        nonfinite_bump = (verdict == VERDICT_NONFINITE) ? bump(nonfinite_reg) : nonfinite_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            kept_reg      <= '0;
            removed_reg   <= '0;
            nonfinite_reg <= '0;
        end else if (en) begin
            v1_reg      <= !empty;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
            if (v3_reg) begin
                kept_reg      <= last3_reg ? '0 : kept_bump;
                removed_reg   <= last3_reg ? '0 : removed_bump;
                nonfinite_reg <= last3_reg ? '0 : nonfinite_bump;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph1_reg   <= ph_next;
            pl1_reg   <= pl_next;
            nf1_reg   <= head.nonfinite;
            last1_reg <= head.last;
            prod2_reg <= prod_next;
            nf2_reg   <= nf1_reg;
            last2_reg <= last1_reg;
            axis3_reg <= axis_next;
            nf3_reg   <= nf2_reg;
            last3_reg <= last2_reg;
            if (v3_reg) begin
                m_data_reg <= M_TDATA_WIDTH'({OUT_COUNT_WIDTH'(nonfinite_bump),
                                             OUT_COUNT_WIDTH'(removed_bump),
                                             OUT_COUNT_WIDTH'(kept_bump)});
                m_user_reg <= verdict;
                m_last_reg <= last3_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: design/rigid_transform_crop_box_filter_top.sv
// Rigid-transform crop box filter: one point a cycle, rotated by a quaternion, translated,
// tested against an inclusive box, with saturating per-cloud counts. The block takes one
// point every clock cycle unless the queue, the output or a quaternion write holds it off,
// and returns one result word per point, in order. That rate is set by the multiplier array,
// which forms all eighteen coefficient-by-coordinate partial products of a point in one
// pipeline stage. After a write to the quaternion register the input is held off while
// the rotation coefficients are recomputed. A four-word queue separates the input stage
// from the transform pipeline so that each side can stall on its own.
// Depends on rtcbf_pkg, rtcbf_cfg, rtcbf_front, rtcbf_queue, rtcbf_back and the macro header.
`timescale 1ns / 1ps
`include "rigid_transform_crop_box_filter_top_macros.svh"

module rigid_transform_crop_box_filter_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rtcbf_pkg::S_TDATA_WIDTH-1:0]   s_tdata,  // coord_x, coord_y, coord_z
    input  logic [rtcbf_pkg::S_TUSER_WIDTH-1:0]   s_tuser,  // not_finite
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rtcbf_pkg::M_TDATA_WIDTH-1:0]   m_tdata,  // kept_total, removed_total,
                                                            // nonfinite_total
    output logic [rtcbf_pkg::M_TUSER_WIDTH-1:0]   m_tuser,  // verdict
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rtcbf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rtcbf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import rtcbf_pkg::*;

    xform_t xform;
    point_t push_item;
    point_t head;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    rtcbf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .xform     (xform)
    );

    rtcbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .busy      (xform.busy),
        .full      (q_full),
        .push      (q_push),
        .push_item (push_item)
    );

    rtcbf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rtcbf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .xform    (xform),
        .head     (head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `RTCBF_ASSERT_NEVER(a_queue_no_overflow, aclk, aresetn, q_push && q_full)
    `RTCBF_ASSERT_NEVER(a_queue_no_underflow, aclk, aresetn, q_pop && q_empty)
    `RTCBF_ASSERT_IMPLY(a_settle_blocks_input, aclk, aresetn, xform.busy, !s_tready)
    `RTCBF_ASSERT_NEXT(a_quat_write_stalls, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == REG_QUAT, !s_tready)

endmodule

// File: bench/tb_rigid_transform_crop_box_filter_top.sv
// Self-checking bench for the rigid-transform crop box filter: directed edge points, then
// random clouds under several register settings, each word checked against a local predictor.
// Depends on rtcbf_pkg and rigid_transform_crop_box_filter_top.
`timescale 1ns / 1ps

module tb_rigid_transform_crop_box_filter_top;
    import rtcbf_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int REPORT_LIMIT     = 100;
    localparam int RANDOM_SETTINGS  = 8;
    localparam int POINTS_PER_SET   = 220;
    localparam int PRESSURE_POINTS  = 60;
    localparam int NEAR_SPAN        = 1 << 20;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = CFG_INDEX_WIDTH'(7);

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_WIDTH-1:0] ONE_M = 32'sh0001_0000;
    localparam logic [63:0] FULL_RANGE = {32'h7FFF_FFFF, 32'h8000_0000};
    localparam logic signed [39:0] UNIT = 40'sd1 <<< CFRAC;

    typedef struct packed {
        logic [VERDICT_WIDTH-1:0]   verdict;
        logic [OUT_COUNT_WIDTH-1:0] kept;
        logic [OUT_COUNT_WIDTH-1:0] removed;
        logic [OUT_COUNT_WIDTH-1:0] nonfinite;
        logic                       end_of_cloud;
    } tally_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_WIDTH-1:0]   s_tdata   = '0;
    logic [S_TUSER_WIDTH-1:0]   s_tuser   = '0;
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;
    logic [M_TUSER_WIDTH-1:0]   m_tuser;
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    // Predictor copy of the registers and the per-cloud counters.
    logic [63:0]                   rot_quat  = QUAT_RESET;
    logic signed [COORD_WIDTH-1:0] shift_xyz [3] = '{default: '0};
    logic [63:0]                   box_lim   [3] = '{default: '0};
    logic [COUNT_WIDTH-1:0]        kept_cnt      = '0;
    logic [COUNT_WIDTH-1:0]        removed_cnt   = '0;
    logic [COUNT_WIDTH-1:0]        nonfinite_cnt = '0;

    point_t pending_points [$];
    tally_t expected_tallies [$];

    int  mismatches     = 0;
    int  words_seen     = 0;
    int  cycle_count    = 0;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    int  sink_hold_req  = 0;
    int  sink_hold_seen = 0;
    int  sink_hold_left = 0;
    bit  src_idle_on    = 1'b1;
    bit  sink_idle_on   = 1'b1;

    rigid_transform_crop_box_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // coord_x, coord_y, coord_z
        .s_tuser   (s_tuser),   // not_finite
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // kept_total, removed_total, nonfinite_total
        .m_tuser   (m_tuser),   // verdict
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Rotates, translates and box-tests one point, then advances the cloud counters.
    function automatic tally_t classify_point(input point_t p);
        logic signed [QUAT_WIDTH-1:0] qx, qy, qz, qw;
        logic signed [39:0]           m [3][3];
        logic signed [95:0]           coord [3];
        logic signed [95:0]           pos;
        logic                         inside_box;
        tally_t                       t;
        qx = rot_quat[0 +: QUAT_WIDTH];
        qy = rot_quat[QUAT_WIDTH +: QUAT_WIDTH];
        qz = rot_quat[2*QUAT_WIDTH +: QUAT_WIDTH];
        qw = rot_quat[3*QUAT_WIDTH +: QUAT_WIDTH];
        m[0][0] = UNIT - 2 * (qy * qy + qz * qz);
        m[0][1] = 2 * (qx * qy - qz * qw);
        m[0][2] = 2 * (qx * qz + qy * qw);
        m[1][0] = 2 * (qx * qy + qz * qw);
        m[1][1] = UNIT - 2 * (qx * qx + qz * qz);
        m[1][2] = 2 * (qy * qz - qx * qw);
        m[2][0] = 2 * (qx * qz - qy * qw);
        m[2][1] = 2 * (qy * qz + qx * qw);
        m[2][2] = UNIT - 2 * (qx * qx + qy * qy);
        coord[0] = 96'(p.x);
        coord[1] = 96'(p.y);
        coord[2] = 96'(p.z);
        inside_box = 1'b1;
        for (int r = 0; r < 3; r++) begin
            pos = ((m[r][0] * coord[0] + m[r][1] * coord[1] + m[r][2] * coord[2]) >>> CFRAC)
                  + shift_xyz[r];
            if (pos < $signed(box_lim[r][31:0]) || pos > $signed(box_lim[r][63:32]))
                inside_box = 1'b0;
        end
        if (p.nonfinite) begin
            t.verdict = VERDICT_NONFINITE;
            if (!(&nonfinite_cnt)) nonfinite_cnt++;
        end else if (inside_box) begin
            t.verdict = VERDICT_REMOVED;
            if (!(&removed_cnt)) removed_cnt++;
        end else begin
            t.verdict = VERDICT_KEPT;
            if (!(&kept_cnt)) kept_cnt++;
        end
        t.kept         = kept_cnt;
        t.removed      = removed_cnt;
        t.nonfinite    = nonfinite_cnt;
        t.end_of_cloud = p.last;
        if (p.last) begin
            kept_cnt      = '0;
            removed_cnt   = '0;
            nonfinite_cnt = '0;
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        if (mismatches < REPORT_LIMIT)
            $display("mismatch at word %0d: %s got %0h expected %0h",
                     words_seen, what, got_v, want_v);
        mismatches++;
    endtask

    always @(posedge aclk) begin : point_driver
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_tallies.push_back(classify_point(pending_points.pop_front()));
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
            end else if (pending_points.size() > 0) begin
                if (src_idle_on && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(0, 3);
                else
                    offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {pending_points[0].z, pending_points[0].y, pending_points[0].x};
                s_tuser <= pending_points[0].nonfinite;
                s_tlast <= pending_points[0].last;
            end
        end
    end

    always @(posedge aclk) begin : sink_hold_timer
        if (!aresetn) begin
            sink_hold_left <= 0;
        end else if (sink_hold_seen != sink_hold_req) begin
            sink_hold_seen <= sink_hold_req;
            sink_hold_left <= SINK_HOLD_CYCLES;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        tally_t got, want;
        logic   rdy;
        rdy = 1'b0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.verdict      = m_tuser;
                got.kept         = m_tdata[0 +: OUT_COUNT_WIDTH];
                got.removed      = m_tdata[OUT_COUNT_WIDTH +: OUT_COUNT_WIDTH];
                got.nonfinite    = m_tdata[2*OUT_COUNT_WIDTH +: OUT_COUNT_WIDTH];
                got.end_of_cloud = m_tlast;
                if (expected_tallies.size() == 0) begin
                    report_mismatch("unexpected word, verdict", 64'(got.verdict), '0);
                end else begin
                    want = expected_tallies.pop_front();
                    if (got.verdict != want.verdict)
                        report_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
                    if (got.kept != want.kept)
                        report_mismatch("kept_total", 64'(got.kept), 64'(want.kept));
                    if (got.removed != want.removed)
                        report_mismatch("removed_total", 64'(got.removed),
                                        64'(want.removed));
                    if (got.nonfinite != want.nonfinite)
                        report_mismatch("nonfinite_total", 64'(got.nonfinite),
                                        64'(want.nonfinite));
                    if (got.end_of_cloud != want.end_of_cloud)
                        report_mismatch("end_of_cloud", 64'(got.end_of_cloud),
                                        64'(want.end_of_cloud));
                end
                words_seen++;
            end
            if (sink_hold_left != 0) begin
                rdy = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 3);
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int around_zero(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            p.x = around_zero(NEAR_SPAN);
            p.y = around_zero(NEAR_SPAN);
            p.z = around_zero(NEAR_SPAN);
        end else if (sel < 18) begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end else begin
            p.x = $urandom_range(0, 1) ? C_MAX : C_MIN;
            p.y = $urandom_range(0, 1) ? C_MAX : C_MIN;
            p.z = $urandom_range(0, 1) ? C_MAX : C_MIN;
        end
        p.nonfinite = ($urandom_range(0, 9) == 0);
        p.last      = ($urandom_range(0, 24) == 0);
        return p;
    endfunction

    task automatic push_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y,
                              input logic signed [COORD_WIDTH-1:0] z,
                              input logic nonfinite, input logic last);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.nonfinite = nonfinite;
        p.last = last;
        pending_points.push_back(p);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_QUAT:    rot_quat = val;
            REG_TRANS_X: shift_xyz[0] = val[31:0];
            REG_TRANS_Y: shift_xyz[1] = val[31:0];
            REG_TRANS_Z: shift_xyz[2] = val[31:0];
            REG_BOX_X:   box_lim[0] = val;
            REG_BOX_Y:   box_lim[1] = val;
            REG_BOX_Z:   box_lim[2] = val;
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [63:0] q, input logic signed [31:0] tx,
                                input logic signed [31:0] ty, input logic signed [31:0] tz,
                                input logic [63:0] bx, input logic [63:0] by,
                                input logic [63:0] bz);
        write_register(REG_QUAT, q);
        write_register(REG_TRANS_X, {$urandom, tx});
        write_register(REG_TRANS_Y, {$urandom, ty});
        write_register(REG_TRANS_Z, {$urandom, tz});
        write_register(REG_BOX_X, bx);
        write_register(REG_BOX_Y, by);
        write_register(REG_BOX_Z, bz);
    endtask

    task automatic random_setting();
        logic [63:0]        q;
        logic [63:0]        b [3];
        logic signed [31:0] t [3];
        int                 lo, hi, w;
        case ($urandom_range(0, 3))
            0: q = {$urandom, $urandom};
            1: q = QUAT_RESET;
            default: q = {16'($urandom_range(20000, 32767)), 16'(around_zero(12000)),
                          16'(around_zero(12000)), 16'(around_zero(12000))};
        endcase
        for (int r = 0; r < 3; r++) begin
            t[r] = ($urandom_range(0, 4) == 0) ? $urandom : around_zero(1 << 19);
            lo = around_zero(NEAR_SPAN);
            w  = $urandom_range(1 << 19, 1 << 22);
            hi = lo + w;
            if ($urandom_range(0, 7) == 0)
                b[r] = {$urandom, $urandom};
            else if ($urandom_range(0, 5) == 0)
                b[r] = {32'(lo), 32'(hi)};
            else
                b[r] = {32'(hi), 32'(lo)};
        end
        load_setting(q, t[0], t[1], t[2], b[0], b[1], b[2]);
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (pending_points.size() != 0 || expected_tallies.size() != 0);
    endtask

    initial begin : main_sequence
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers at their reset values: identity rotation, box pinned at the origin.
        @(negedge aclk);
        push_point(0, 0, 0, 1'b0, 1'b0);
        push_point(1, 0, 0, 1'b0, 1'b0);
        push_point(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
        push_point(C_MIN, C_MIN, C_MIN, 1'b0, 1'b0);
        push_point(0, 0, 0, 1'b1, 1'b0);
        push_point(C_MAX, C_MIN, 0, 1'b1, 1'b1);
        push_point(0, 0, 0, 1'b0, 1'b1);
        wait_idle();

        // Inclusive box edges: points on the edges and one step outside them on every axis.
        write_register(REG_SPARE, {$urandom, $urandom});
        load_setting(QUAT_RESET, ONE_M, -2 * ONE_M, 0,
                     {32'(2 * ONE_M), 32'(-ONE_M)},
                     {32'(4 * ONE_M), 32'(-4 * ONE_M)},
                     {32'h0000_8000, 32'h0000_0000});
        @(negedge aclk);
        push_point(-2 * ONE_M, 2 * ONE_M, 0, 1'b0, 1'b0);
        push_point(-2 * ONE_M - 1, 2 * ONE_M, 0, 1'b0, 1'b0);
        push_point(ONE_M, 2 * ONE_M, 0, 1'b0, 1'b0);
        push_point(ONE_M + 1, 2 * ONE_M, 0, 1'b0, 1'b0);
        push_point(0, 6 * ONE_M, 0, 1'b0, 1'b0);
        push_point(0, -2 * ONE_M - 1, 0, 1'b0, 1'b0);
        push_point(0, 2 * ONE_M, 32'sh0000_8000, 1'b0, 1'b0);
        push_point(0, 2 * ONE_M, 32'sh0000_8001, 1'b0, 1'b0);
        push_point(0, 2 * ONE_M, -1, 1'b0, 1'b1);
        wait_idle();

        // A y range whose minimum lies above its maximum removes nothing.
        write_register(REG_BOX_Y, {32'(-ONE_M), 32'(ONE_M)});
        @(negedge aclk);
        push_point(0, 2 * ONE_M, 0, 1'b0, 1'b1);
        wait_idle();

        // Extreme, non-normalized quaternions with translations at the ends of the range.
        load_setting(64'h8000_8000_8000_8000, C_MAX, C_MIN, C_MAX,
                     FULL_RANGE, FULL_RANGE, FULL_RANGE);
        @(negedge aclk);
        push_point(0, 0, 0, 1'b0, 1'b0);
        push_point(ONE_M, 0, 0, 1'b0, 1'b0);
        push_point(-ONE_M, 0, 0, 1'b0, 1'b0);
        push_point(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
        push_point(C_MIN, C_MIN, C_MIN, 1'b0, 1'b1);
        wait_idle();
        write_register(REG_QUAT, 64'h7FFF_7FFF_7FFF_7FFF);
        @(negedge aclk);
        push_point(C_MIN, C_MAX, C_MIN, 1'b0, 1'b0);
        push_point(ONE_M, -ONE_M, ONE_M, 1'b0, 1'b0);
        wait_idle();
        write_register(REG_QUAT, 64'h0);
        @(negedge aclk);
        push_point(ONE_M, ONE_M, ONE_M, 1'b0, 1'b1);
        wait_idle();

        // The receiver holds off for a long stretch while points keep coming.
        random_setting();
        @(negedge aclk);
        src_idle_on = 1'b0;
        sink_hold_req++;
        repeat (PRESSURE_POINTS) pending_points.push_back(random_point());
        wait_idle();
        src_idle_on = 1'b1;

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            random_setting();
            @(negedge aclk);
            if (s == RANDOM_SETTINGS - 1) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            repeat (POINTS_PER_SET) pending_points.push_back(random_point());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_tallies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
